@@ rtl/eps_pkg.sv @@
package eps_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int DT_BITS          = 16;
   localparam int REG_W            = 32;

   localparam logic signed [36:0] Q30_PI      = 37'sd3373259426;
   localparam logic signed [36:0] Q30_TWO_PI  = 37'sd6746518852;
   localparam logic signed [36:0] Q30_HALF_PI = 37'sd1686629713;
   localparam logic signed [36:0] Q30_GAIN    = 37'sd652032874;

   localparam logic [2:0] CSR_GRAVITY   = 3'd0;
   localparam logic [2:0] CSR_REST_LEN  = 3'd1;
   localparam logic [2:0] CSR_STIFFNESS = 3'd2;
   localparam logic [2:0] CSR_START_ANG = 3'd3;
   localparam logic [2:0] CSR_START_STR = 3'd4;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            5'd0: r = 32'sd843314856;
            5'd1: r = 32'sd497837829;
            5'd2: r = 32'sd263043836;
            5'd3: r = 32'sd133525158;
            5'd4: r = 32'sd67021686;
            5'd5: r = 32'sd33543515;
            5'd6: r = 32'sd16775850;
            5'd7: r = 32'sd8388437;
            5'd8: r = 32'sd4194282;
            5'd9: r = 32'sd2097149;
            5'd10: r = 32'sd1048575;
            5'd11: r = 32'sd524287;
            5'd12: r = 32'sd262143;
            5'd13: r = 32'sd131071;
            5'd14: r = 32'sd65535;
            5'd15: r = 32'sd32767;
            5'd16: r = 32'sd16383;
            5'd17: r = 32'sd8191;
            5'd18: r = 32'sd4095;
            5'd19: r = 32'sd2047;
            5'd20: r = 32'sd1023;
            5'd21: r = 32'sd511;
            5'd22: r = 32'sd255;
            5'd23: r = 32'sd127;
            5'd24: r = 32'sd63;
            5'd25: r = 32'sd31;
            5'd26: r = 32'sd15;
            5'd27: r = 32'sd7;
            5'd28: r = 32'sd3;
            5'd29: r = 32'sd1;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ rtl/eps_cordic.sv @@
// Iterative sin/cos: range reduction, then one rotation per cycle.
module eps_cordic import eps_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] theta,
   output logic               done,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam int OSH   = 30 - FRAC_BITS;
   // scaled angle needs 32 + OSH bits; the largest multiple of 2*pi one more
   localparam int ZW    = OSH + 34;
   localparam int KTOP  = OSH - 1;

   typedef enum logic [2:0] {C_IDLE, C_MOD, C_WRAP, C_FOLD, C_ROT, C_OUT} cstate_type;

   cstate_type         state_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [36:0] x_ff, y_ff;
   logic               neg_ff;
   logic [5:0]         i_ff;
   logic               done_ff;
   logic signed [31:0] sin_ff, cos_ff;

   logic signed [36:0] yshift, xshift;
   logic signed [36:0] xneg, yneg;

   // reduction modulo 2*pi: restoring subtract of 2*pi*2^k, k from KTOP down to 0
   logic [4:0]         k_ff;
   logic signed [ZW-1:0] mult;
   logic [ZW-1:0]      zabs;

   assign yshift = y_ff >>> i_ff[4:0];
   assign xshift = x_ff >>> i_ff[4:0];
   assign xneg   = -x_ff;
   assign yneg   = -y_ff;
   assign zabs   = z_ff[ZW-1] ? ZW'(-z_ff) : ZW'(z_ff);
   assign mult   = ZW'(Q30_TWO_PI) <<< k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  z_ff     <= ZW'(theta) <<< OSH;
                  k_ff     <= 5'(KTOP);
                  state_ff <= C_MOD;
               end
            end
            C_MOD: begin
               // truncated remainder: shrink magnitude keeping sign
               if (zabs >= $unsigned(mult)) begin
                  z_ff <= z_ff[ZW-1] ? z_ff + mult : z_ff - mult;
               end
               if (k_ff == 5'd0) state_ff <= C_WRAP;
               else k_ff <= k_ff - 5'd1;
            end
            C_WRAP: begin
               if (z_ff > ZW'(Q30_PI)) z_ff <= z_ff - ZW'(Q30_TWO_PI);
               else if (z_ff < -ZW'(Q30_PI)) z_ff <= z_ff + ZW'(Q30_TWO_PI);
               state_ff <= C_FOLD;
            end
            C_FOLD: begin
               neg_ff <= 1'b0;
               if (z_ff > ZW'(Q30_HALF_PI)) begin
                  z_ff <= z_ff - ZW'(Q30_PI);
                  neg_ff <= 1'b1;
               end else if (z_ff < -ZW'(Q30_HALF_PI)) begin
                  z_ff <= z_ff + ZW'(Q30_PI);
                  neg_ff <= 1'b1;
               end
               x_ff     <= Q30_GAIN;
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= (STEPS == 0) ? C_OUT : C_ROT;
            end
            C_ROT: begin
               if (!z_ff[ZW-1]) begin
                  x_ff <= x_ff - yshift;
                  y_ff <= y_ff + xshift;
                  z_ff <= z_ff - ZW'(atan_q30(i_ff[4:0]));
               end else begin
                  x_ff <= x_ff + yshift;
                  y_ff <= y_ff - xshift;
                  z_ff <= z_ff + ZW'(atan_q30(i_ff[4:0]));
               end
               i_ff <= i_ff + 6'd1;
               if (i_ff == 6'(STEPS - 1)) state_ff <= C_OUT;
            end
            C_OUT: begin
               sin_ff   <= 32'((neg_ff ? yneg : y_ff) >>> OSH);
               cos_ff   <= 32'((neg_ff ? xneg : x_ff) >>> OSH);
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

@@ rtl/eps_divider.sv @@
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module eps_divider import eps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] numer,
   input  logic signed [33:0] denom,
   output logic               done,
   output logic signed [63:0] quot
);

   logic [63:0] q_ff;
   logic [63:0] r_ff;
   logic [63:0] d_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [64:0] trial;

   assign trial = {r_ff, q_ff[63]} - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff    <= numer[63] ? 64'(-numer) : 64'(numer);
            d_ff    <= 64'(denom);
            r_ff    <= '0;
            neg_ff  <= numer[63];
            cnt_ff  <= 7'd64;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[64]) begin
               r_ff <= trial[63:0];
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= {r_ff[62:0], q_ff[63]};
               q_ff <= {q_ff[62:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

@@ rtl/elastic_pendulum_step.sv @@
// Elastic pendulum stepper. Each req transfer (mode, step_time) either restarts from
// start_angle/start_stretch or advances one modified-Euler step; one rsp transfer
// returns angle, stretch and fault. One item at a time: a step is set by a shared
// 34x33 multiplier sequencer, up to three serial CORDIC passes and up to two serial
// divisions. A restart goes from idle straight to the result register. req_tready is
// high only while idle; a finished item waits until the result register is free
// before the block goes idle.
module elastic_pendulum_step import eps_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // step_time[15:0]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // angle[31:0], stretch[63:32], fault[64], zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE, S_T1, S_T1W, S_T1A, S_T1B, S_T1C, S_T1D, S_T1DIV, S_T1Q,
      S_HALF1, S_T2, S_T2W, S_T2A, S_T2B, S_T2C, S_T2D, S_T2DIV, S_T2Q,
      S_W1, S_X0, S_XW, S_XA, S_XB, S_XC, S_XD, S_XE, S_V, S_W2, S_HALF2, S_RSP
   } state_type;

   state_type          state_ff;
   logic [30:0]        grav_ff, rest_ff, kpm_ff;
   logic signed [31:0] sang_ff, sstr_ff;
   logic signed [31:0] th_ff, w_ff, x_ff, v_ff, w0_ff, v0_ff;
   logic signed [31:0] k_ff, t_ff, s_ff, half_ff;
   logic [15:0]        dt_ff;
   logic               flt_ff;
   logic               rv_ff;
   logic signed [31:0] ra_ff, rx_ff;
   logic               rf_ff;

   // shared multiplier: operands registered, product registered
   logic signed [33:0] ma_ff;
   logic signed [32:0] mb_ff;
   logic signed [66:0] prod_ff;
   logic [5:0]         mwait_ff;

   logic signed [33:0] den;
   logic signed [63:0] pfs, pd16, pd17;
   logic signed [63:0] s1, s2, s3;
   logic               c_start, c_done, d_start, d_done;
   logic signed [31:0] c_sin, c_cos;
   logic signed [31:0] c_theta;
   logic signed [63:0] d_num, d_q;

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v, output logic o);
      begin
         o = 1'b0;
         if (v > SAT_MAX) begin o = 1'b1; return 32'sh7FFFFFFF; end
         if (v < SAT_MIN) begin o = 1'b1; return 32'sh80000000; end
         return v[31:0];
      end
   endfunction

   assign den  = 34'(signed'({1'b0, rest_ff})) + 34'(x_ff);
   assign pfs  = 64'(prod_ff >>> FRAC_BITS);
   assign pd16 = 64'(prod_ff >>> DT_BITS);
   assign pd17 = 64'(prod_ff >>> (DT_BITS + 1));

   assign c_theta = th_ff;
   // no CORDIC pass when the angular term is skipped, so none is left running
   assign c_start = (((state_ff == S_T1) || (state_ff == S_T2)) && (den > 34'sd0)) ||
                    (state_ff == S_X0);
   assign d_start = (state_ff == S_T1D) || (state_ff == S_T2D);
   assign d_num   = 64'(t_ff) <<< FRAC_BITS;

   eps_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(c_start), .theta(c_theta),
      .done(c_done), .sin_out(c_sin), .cos_out(c_cos)
   );

   eps_divider u_div (
      .clock(clock), .reset(reset), .start(d_start), .numer(d_num),
      .denom(den), .done(d_done), .quot(d_q)
   );

   always_ff @(posedge clock) begin
      prod_ff <= ma_ff * mb_ff;
   end

   always_ff @(posedge clock) begin
      logic o1, o2, o3;
      logic signed [31:0] a1, a2, a3;
      if (reset) begin
         state_ff <= S_IDLE;
         grav_ff  <= 31'd642908;
         rest_ff  <= 31'd65536;
         kpm_ff   <= 31'd655360;
         sang_ff  <= '0;
         sstr_ff  <= '0;
         th_ff <= '0; w_ff <= '0; x_ff <= '0; v_ff <= '0;
         rv_ff    <= 1'b0;
         mwait_ff <= '0;
      end else begin
         o1 = 1'b0; o2 = 1'b0; o3 = 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GRAVITY:   grav_ff <= csr_wdata[30:0];
               CSR_REST_LEN:  rest_ff <= csr_wdata[30:0];
               CSR_STIFFNESS: kpm_ff  <= csr_wdata[30:0];
               CSR_START_ANG: sang_ff <= csr_wdata;
               CSR_START_STR: sstr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rv_ff && rsp_tready && (state_ff != S_RSP)) rv_ff <= 1'b0;
         if (mwait_ff != 6'd0) mwait_ff <= mwait_ff - 6'd1;
         unique case (state_ff) inside
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  dt_ff  <= req_tdata;
                  flt_ff <= 1'b0;
                  w0_ff  <= w_ff;
                  v0_ff  <= v_ff;
                  if (req_tuser) begin
                     th_ff <= sang_ff; x_ff <= sstr_ff; w_ff <= '0; v_ff <= '0;
                     state_ff <= S_RSP;
                  end else begin
                     state_ff <= S_T1;
                  end
               end
            end
            // ---- tacc, shared by both half-steps ----
            S_T1, S_T2: begin
               if (den <= 0) begin
                  flt_ff <= 1'b1;
                  k_ff <= '0;
                  state_ff <= (state_ff == S_T1) ? S_HALF1 : S_W1;
               end else begin
                  state_ff <= (state_ff == S_T1) ? S_T1W : S_T2W;
               end
            end
            S_T1W, S_T2W: begin
               if (c_done) begin
                  s_ff  <= c_sin;
                  ma_ff <= 34'(signed'({1'b0, grav_ff}));
                  mb_ff <= 33'(c_sin);
                  mwait_ff <= 6'd2;
                  state_ff <= (state_ff == S_T1W) ? S_T1A : S_T2A;
               end
            end
            S_T1A, S_T2A: begin
               if (mwait_ff == 6'd0) begin
                  t_ff  <= sat64(pfs, o1);
                  flt_ff <= flt_ff | o1;
                  ma_ff <= 34'(v_ff);
                  mb_ff <= 33'((state_ff == S_T1A) ? w_ff : half_ff);
                  mwait_ff <= 6'd2;
                  state_ff <= (state_ff == S_T1A) ? S_T1B : S_T2B;
               end
            end
            S_T1B, S_T2B: begin
               if (mwait_ff == 6'd0) begin
                  a1 = sat64(pfs, o1);
                  a2 = sat64(64'(a1) * 64'sd2, o2);
                  a3 = sat64(64'(t_ff) + 64'(a2), o3);
                  t_ff <= a3;
                  flt_ff <= flt_ff | o1 | o2 | o3;
                  state_ff <= (state_ff == S_T1B) ? S_T1C : S_T2C;
               end
            end
            S_T1C: state_ff <= S_T1D;
            S_T2C: state_ff <= S_T2D;
            S_T1D: state_ff <= S_T1DIV;
            S_T2D: state_ff <= S_T2DIV;
            S_T1DIV, S_T2DIV: begin
               if (d_done) begin
                  k_ff <= sat64(-d_q, o1);
                  flt_ff <= flt_ff | o1;
                  state_ff <= (state_ff == S_T1DIV) ? S_T1Q : S_T2Q;
               end
            end
            S_T1Q: state_ff <= S_HALF1;
            S_T2Q: state_ff <= S_W1;
            // ---- first drift, then w + dt*k1/2 ----
            S_HALF1: begin
               // sequenced through multiplier: w0*dt, v0*dt, k1*dt
               case (mwait_ff)
                  6'd0: begin
                     ma_ff <= 34'(w0_ff); mb_ff <= 33'({1'b0, dt_ff});
                     mwait_ff <= 6'd8;
                  end
                  6'd6: begin
                     a1 = sat64(64'(th_ff) + pd17, o1);
                     th_ff <= a1; flt_ff <= flt_ff | o1;
                     ma_ff <= 34'(v0_ff);
                  end
                  6'd4: begin
                     a1 = sat64(64'(x_ff) + pd17, o1);
                     x_ff <= a1; flt_ff <= flt_ff | o1;
                     ma_ff <= 34'(k_ff);
                  end
                  6'd2: begin
                     a1 = sat64(64'(w_ff) + pd17, o1);
                     half_ff <= a1; flt_ff <= flt_ff | o1;
                     state_ff <= S_T2;
                  end
                  default: ;
               endcase
            end
            // ---- w += dt*k2/2 ----
            S_W1: begin
               case (mwait_ff)
                  6'd0: begin
                     ma_ff <= 34'(k_ff); mb_ff <= 33'({1'b0, dt_ff});
                     mwait_ff <= 6'd3;
                  end
                  6'd1: begin
                     half_ff <= pd17[31:0];
                     a1 = sat64(64'(w_ff) + pd17, o1);
                     w_ff <= a1; flt_ff <= flt_ff | o1;
                     state_ff <= S_X0;
                  end
                  default: ;
               endcase
            end
            // ---- xacc ----
            S_X0: state_ff <= S_XW;
            S_XW: begin
               if (c_done) begin
                  s_ff <= c_cos;
                  ma_ff <= 34'(w_ff); mb_ff <= 33'(w_ff);
                  mwait_ff <= 6'd2;
                  state_ff <= S_XA;
               end
            end
            S_XA: begin
               if (mwait_ff == 6'd0) begin
                  t_ff <= sat64(pfs, o1); flt_ff <= flt_ff | o1;
                  ma_ff <= den; mb_ff <= 33'(sat64(pfs, o2));
                  mwait_ff <= 6'd2;
                  state_ff <= S_XB;
               end
            end
            S_XB: begin
               if (mwait_ff == 6'd0) begin
                  t_ff <= sat64(pfs, o1); flt_ff <= flt_ff | o1;
                  ma_ff <= 34'(signed'({1'b0, grav_ff})); mb_ff <= 33'(s_ff);
                  mwait_ff <= 6'd2;
                  state_ff <= S_XC;
               end
            end
            S_XC: begin
               if (mwait_ff == 6'd0) begin
                  s_ff <= sat64(pfs, o1); flt_ff <= flt_ff | o1;
                  ma_ff <= 34'(signed'({1'b0, kpm_ff})); mb_ff <= 33'(x_ff);
                  mwait_ff <= 6'd2;
                  state_ff <= S_XD;
               end
            end
            S_XD: begin
               if (mwait_ff == 6'd0) begin
                  a1 = sat64(pfs, o1);
                  a2 = sat64(64'(t_ff) + 64'(s_ff) - 64'(a1), o2);
                  flt_ff <= flt_ff | o1 | o2;
                  ma_ff <= 34'(a2); mb_ff <= 33'({1'b0, dt_ff});
                  mwait_ff <= 6'd2;
                  state_ff <= S_XE;
               end
            end
            S_XE: begin
               if (mwait_ff == 6'd0) begin
                  a1 = sat64(64'(v_ff) + pd16, o1);
                  v_ff <= a1; flt_ff <= flt_ff | o1;
                  state_ff <= S_V;
               end
            end
            S_V: begin
               a1 = sat64(64'(w_ff) + 64'(half_ff), o1);
               w_ff <= a1; flt_ff <= flt_ff | o1;
               state_ff <= S_W2;
            end
            S_W2: begin
               ma_ff <= 34'(w0_ff); mb_ff <= 33'({1'b0, dt_ff});
               mwait_ff <= 6'd6;
               state_ff <= S_HALF2;
            end
            S_HALF2: begin
               case (mwait_ff)
                  6'd4: begin
                     a1 = sat64(64'(th_ff) + pd17, o1);
                     th_ff <= a1; flt_ff <= flt_ff | o1;
                     ma_ff <= 34'(v0_ff);
                  end
                  6'd2: begin
                     a1 = sat64(64'(x_ff) + pd17, o1);
                     x_ff <= a1; flt_ff <= flt_ff | o1;
                     state_ff <= S_RSP;
                  end
                  default: ;
               endcase
            end
            S_RSP: begin
               if (!rv_ff || rsp_tready) begin
                  ra_ff <= th_ff;
                  rx_ff <= x_ff;
                  rf_ff <= flt_ff;
                  rv_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign s1 = '0;
   assign s2 = s1;
   assign s3 = s2;

   assign req_tready = (state_ff == S_IDLE) && (s3 == 64'sd0);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0, rf_ff, rx_ff, ra_ff};

`ifndef SYNTH
   a_rdy_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("accepted item lost");
`endif

endmodule
